FILE: src/pss_pkg.sv
// process slot scheduler package: command and status codes, shared structs
// no dependencies
package pss_pkg;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSTALL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KILL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_KILLM   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_ACTV = 2'd2;

  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      pid;
    logic [31:0]      pid_mask;
    logic [4:0]       slot;
    logic [15:0]      new_sleep;
    logic             current_valid;
    logic [4:0]       current_slot;
  } pss_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  slot_out;
    logic [31:0] pid_out;
    logic [5:0]  kill_count;
    logic        none_ready;
    logic        last;
  } pss_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input beat, reset walk
    logic start;     // marks walk start; unused by the datapath, where load moves the cursor to list head
    logic step;      // process cursor entry and advance
    logic install;
    logic report;
    logic kill;
    logic emit_done; // build final result
    logic emit_pop;  // result taken
  } pss_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_end;  // cursor null, step count exhausted or tick result limit reached
    logic found;     // target slot seen during walk
    logic hit;       // current step produces a tick result
    logic out_full;  // result register occupied
  } pss_sts_t;

endpackage

FILE: src/pss_if.sv
// valid/ready channel carrying one payload type
// depends on nothing
interface pss_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/process_slot_scheduler_unit.sv
// process slot scheduler top level: controller plus datapath
// one command at a time: the next is accepted only after its result is taken
// tick emits one beat per ready slot walked, up to MAX_RESULTS beats;
// the final hit beat is marked last, or one none_ready beat if none is ready
// reset: synchronous; free stack holds all slots, active list empty
// depends on pss_pkg, pss_if, pss_ctrl, pss_dp
module process_slot_scheduler_unit
  import pss_pkg::*;
#(
  parameter int SLOTS      = 32,
  parameter int SLEEP_BITS = 16
) (
  input logic clk,
  input logic rst,
  pss_if.sink   in_ch,
  pss_if.source out_ch
);

  pss_cmd_t ctl;
  pss_sts_t sts;
  logic     in_fire, out_fire, in_ready, dp_valid;
  pss_out_t dp_data;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = in_ready;

  pss_ctrl u_ctrl (
    .clk, .rst, .in_fire, .cmd(in_ch.data.cmd), .out_fire, .sts, .ctl, .in_ready
  );

  pss_dp #(.SLOTS(SLOTS), .SLEEP_BITS(SLEEP_BITS)) u_dp (
    .clk, .rst, .in_data(in_ch.data), .ctl, .sts,
    .out_valid(dp_valid), .out_data(dp_data)
  );

  assign out_ch.valid = dp_valid;
  assign out_ch.data  = dp_data;

endmodule

FILE: src/pss_ctrl.sv
// process slot scheduler controller: sequences list walks and results
// depends on pss_pkg
module pss_ctrl
  import pss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic [CMD_W-1:0] cmd,
  input  logic     out_fire,
  input  pss_sts_t sts,
  output pss_cmd_t ctl,
  output logic     in_ready
);

  typedef enum logic [2:0] {IDLE, WALK, EXEC, DONE, DRAIN} state_t;
  state_t state, state_next;
  logic [CMD_W-1:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      op    <= CMD_TICK;
    end else begin
      state <= state_next;
      if (in_fire) op <= cmd;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    unique case (state)
      IDLE: if (in_fire) begin
        ctl.load = 1'b1;
        if (cmd <= CMD_READ) begin
          state_next = WALK;
          ctl.start = 1'b1;
        end
      end
      WALK: begin
        if (sts.walk_end) begin
          state_next = (op == CMD_TICK || op == CMD_KILLM) ? DONE : EXEC;
        end else if (!(sts.hit && sts.out_full)) begin
          ctl.step = 1'b1;
        end
      end
      EXEC: begin
        ctl.install = (op == CMD_INSTALL);
        ctl.report  = (op == CMD_REPORT);
        ctl.kill    = (op == CMD_KILL);
        state_next  = DONE;
      end
      DONE: if (!sts.out_full) begin
        ctl.emit_done = 1'b1;
        state_next = DRAIN;
      end
      DRAIN: if (out_fire) state_next = IDLE;
      default: state_next = IDLE;
    endcase
    ctl.emit_pop = out_fire;
  end

endmodule

FILE: src/pss_dp.sv
// process slot scheduler datapath: slot table, list links, walk cursor, result register
// depends on pss_pkg
module pss_dp
  import pss_pkg::*;
#(
  parameter int SLOTS      = 32,
  parameter int SLEEP_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  pss_in_t  in_data,
  input  pss_cmd_t ctl,
  output pss_sts_t sts,
  output logic     out_valid,
  output pss_out_t out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = IW + 1;              // link width, msb set means null
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};
  localparam logic [SLEEP_BITS-1:0] SLEEP_ONE = SLEEP_BITS'(1);

  logic [31:0]           spid   [SLOTS];
  logic [SLEEP_BITS-1:0] ssleep [SLOTS];
  logic [LW-1:0]         snext  [SLOTS];
  logic [SLOTS-1:0]      swait;
  logic [LW-1:0]         active_head, free_head;

  pss_in_t       req;
  logic [LW-1:0] cur, prv, tprev, cur_nxt;
  logic [CW-1:0] cnt;
  logic [6:0]    nres;
  logic [5:0]    killed;
  logic          found, cur_found;
  logic [IW-1:0] ci;
  logic          tick_hit, km_hit, cur_is_run, tgt_ok, run_ok;
  logic [SLEEP_BITS-1:0] dec;
  logic [SLEEP_BITS-1:0] sat_sleep;
  logic [IW-1:0] ti, ri, fi;
  pss_out_t      pend;         // newest tick beat, held until the next hit or the walk end
  logic          pend_valid;

  assign ci = cur[IW-1:0];
  assign cur_nxt = snext[ci];
  assign cur_is_run = req.current_valid && (32'(ci) == 32'(req.current_slot));
  assign dec = (ssleep[ci] != '0) ? ssleep[ci] - SLEEP_ONE : '0;
  assign tick_hit = (req.cmd == CMD_TICK) && !swait[ci] && (dec == '0);
  assign km_hit = (req.cmd == CMD_KILLM) && ((spid[ci] & req.pid_mask) == req.pid)
                  && !cur_is_run;
  assign tgt_ok = (32'(req.slot) < 32'(SLOTS));
  assign ti = IW'(req.slot);
  assign ri = IW'(req.current_slot);
  assign fi = free_head[IW-1:0];
  assign run_ok = (32'(req.current_slot) < 32'(SLOTS));

  always_comb begin
    if (SLEEP_BITS >= 16) sat_sleep = SLEEP_BITS'(req.new_sleep);
    else if ((32'(req.new_sleep) >> SLEEP_BITS) != 0) sat_sleep = '1;
    else sat_sleep = SLEEP_BITS'(req.new_sleep);
  end

  assign sts.walk_end = cur[IW] || (cnt == CW'(SLOTS)) ||
                        (req.cmd == CMD_TICK && nres == 7'(MAX_RESULTS));
  assign sts.found    = found;
  assign sts.hit      = tick_hit;
  assign sts.out_full = out_valid;

  // target matched at cursor: used by report, kill, read, install
  always_comb begin
    unique case (req.cmd)
      CMD_INSTALL: cur_found = req.current_valid && run_ok && (ci == ri);
      default:     cur_found = tgt_ok && (ci == ti);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        snext[i] <= (i + 1 < SLOTS) ? LW'(i + 1) : NIL;
      end
      swait       <= '0;
      active_head <= NIL;
      free_head   <= '0;
      out_valid   <= 1'b0;
      cur <= NIL;
      cnt <= '0;
      nres <= '0;
      killed <= '0;
      found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (ctl.emit_pop) out_valid <= 1'b0;
      if (ctl.load) begin
        req <= in_data;
        cur <= active_head;
        prv <= NIL;
        cnt <= '0;
        nres <= '0;
        killed <= '0;
        found <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (ctl.step) begin
        cnt <= cnt + CW'(1);
        cur <= cur_nxt;
        unique case (req.cmd)
          CMD_TICK: begin
            if (!swait[ci]) ssleep[ci] <= dec;
            if (tick_hit) begin
              swait[ci] <= 1'b1;
              nres <= nres + 7'd1;
              pend <= '{ST_OK, 5'(ci), spid[ci], 6'd0, 1'b0, 1'b0};
              pend_valid <= 1'b1;
              // a later hit proves the held beat is not the final one
              if (pend_valid) begin
                out_valid <= 1'b1;
                out_data  <= pend;
              end
            end
          end
          CMD_KILLM: begin
            if (km_hit) begin
              if (prv[IW]) active_head <= cur_nxt;
              else snext[prv[IW-1:0]] <= cur_nxt;
              snext[ci] <= free_head;
              free_head <= cur;
              swait[ci] <= 1'b0;
              killed <= killed + 6'd1;
            end else begin
              prv <= cur;
            end
          end
          default: begin
            if (!found) begin
              if (cur_found) begin
                found <= 1'b1;
                tprev <= prv;
                cur <= NIL;   // stop walk
              end
              prv <= cur;
            end
          end
        endcase
      end
      if (ctl.install && !free_head[IW]) begin
        free_head <= snext[fi];
        if (found) begin
          snext[fi] <= snext[ri];
          snext[ri] <= free_head;
        end else begin
          snext[fi] <= active_head;
          active_head <= free_head;
        end
        spid[fi]   <= req.pid;
        ssleep[fi] <= SLEEP_ONE;
        swait[fi]  <= 1'b0;
        req.slot   <= 5'(fi);
      end
      if (ctl.install && free_head[IW]) req.slot <= 5'd0;
      if ((ctl.report && found && req.new_sleep == '0) ||
          (ctl.kill && found && !(req.current_valid && req.current_slot == req.slot))) begin
        if (tprev[IW]) active_head <= snext[ti];
        else snext[tprev[IW-1:0]] <= snext[ti];
        snext[ti] <= free_head;
        free_head <= LW'(ti);
        swait[ti] <= 1'b0;
      end
      if (ctl.report && found && req.new_sleep != '0) begin
        ssleep[ti] <= sat_sleep;
        swait[ti]  <= 1'b0;
      end
      if (ctl.install) found <= !free_head[IW];
      if (ctl.emit_done) begin
        out_valid <= 1'b1;
        out_data  <= '0;
        out_data.last <= 1'b1;
        unique case (req.cmd)
          CMD_TICK: begin
            if (nres == '0) out_data.none_ready <= 1'b1;
            else out_data <= '{pend.status, pend.slot_out, pend.pid_out, 6'd0, 1'b0, 1'b1};
          end
          CMD_INSTALL: begin
            if (found) begin
              out_data.slot_out <= req.slot;
              out_data.pid_out  <= req.pid;
            end else begin
              out_data.status <= ST_NO_FREE;
            end
          end
          CMD_KILLM: out_data.kill_count <= killed;
          CMD_KILL: begin
            out_data.slot_out <= req.slot;
            if (!found) out_data.status <= ST_NOT_ACTV;
            else begin
              out_data.pid_out <= spid[ti];
              if (req.current_valid && req.current_slot == req.slot)
                out_data.status <= ST_NOT_ACTV;
            end
          end
          default: begin
            out_data.slot_out <= req.slot;
            if (found) out_data.pid_out <= spid[ti];
            else out_data.status <= ST_NOT_ACTV;
          end
        endcase
      end
    end
  end

endmodule
